/* rtl/sphere_triangle_contact_unit_macros.svh */
// Assertion macros used by the contact unit checker.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef SPHERE_TRIANGLE_CONTACT_UNIT_MACROS_SVH
`define SPHERE_TRIANGLE_CONTACT_UNIT_MACROS_SVH

// Same-cycle implication, off while in reset
`define STC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("contact unit check failed");

// Next-cycle implication, off while in reset
`define STC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("contact unit check failed");

// What must hold in the cycle after a reset edge
`define STC_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("contact unit reset check failed");

`endif

/* rtl/stc_pkg.sv */
`timescale 1ns / 1ps

package stc_pkg;

  // Widths of the exact intermediate values
  localparam int CW        = 32;   // Q16.16 coordinate
  localparam int DFW       = 33;   // coordinate difference
  localparam int PRW       = 66;   // difference product
  localparam int DOTW      = 68;   // dot product of differences
  localparam int VPW       = 136;  // product of two dot products
  localparam int VW        = 137;  // barycentric weight va, vb, vc
  localparam int DENW      = 139;  // quotient divisor
  localparam int NPW       = 170;  // weight times edge component
  localparam int NUMW      = 171;  // quotient numerator
  localparam int DISTW     = 68;   // squared distance
  localparam int RSQW      = 62;   // squared radius

  // Pipeline timing
  localparam int MUL_LAT    = 3;
  localparam int DIV_QBITS  = 36;  // quotient magnitude stays below 2^34
  localparam int PIPE_DEPTH = 10 + 2 * MUL_LAT + DIV_QBITS;

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [DFW-1:0]  diff_t;
  typedef logic signed [PRW-1:0]  prod_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic signed [VPW-1:0]  vprod_t;
  typedef logic signed [VW-1:0]   vol_t;
  typedef logic signed [DENW-1:0] den_t;
  typedef logic signed [NPW-1:0]  nprod_t;
  typedef logic signed [NUMW-1:0] num_t;

  // Triangle geometry carried down the front of the pipe
  typedef struct packed {
    coord_t [2:0] p;
    coord_t [2:0] a;
    coord_t [2:0] b;
    coord_t [2:0] c;
    diff_t  [2:0] ab;
    diff_t  [2:0] ac;
    diff_t  [2:0] bc;
  } geo_t;

  // Geometry plus the six dot products d1..d6 (index 0..5)
  typedef struct packed {
    geo_t        g;
    dot_t [5:0]  d;
  } vctx_t;

  // Context beside the numerator multipliers
  typedef struct packed {
    coord_t [2:0] base;
    coord_t [2:0] p;
    den_t         den;
    logic         deg;
  } ectx_t;

  // Context beside the dividers
  typedef struct packed {
    coord_t [2:0] base;
    coord_t [2:0] p;
    logic   [2:0] nneg;
    logic         dzero;
    logic         deg;
  } qctx_t;

endpackage

/* rtl/stc_mul.sv */
`timescale 1ns / 1ps

// Signed multiplier cut into 33x33 partial products over three stages:
// partial products, row sums, final sum.
module stc_mul #(
  parameter int AW = 68,
  parameter int BW = 68
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CH = 32;
  localparam int NA = (AW + CH - 1) / CH;
  localparam int NB = (BW + CH - 1) / CH;
  localparam int PW = AW + BW;

  logic signed [CH:0]      ach [NA];
  logic signed [CH:0]      bch [NB];
  logic signed [2*CH+1:0]  pp [NA][NB];
  logic signed [PW-1:0]    row [NA];
  logic signed [PW-1:0]    row_next [NA];
  logic signed [PW-1:0]    p_next;

  // Low chunks are unsigned, the top chunk carries the sign
  for (genvar i = 0; i < NA; i++) begin : g_ach
    if (i < NA - 1) begin : g_lo
      assign ach[i] = {1'b0, a[CH*i +: CH]};
    end else begin : g_hi
      assign ach[i] = (CH+1)'($signed(a[AW-1:CH*i]));
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_bch
    if (j < NB - 1) begin : g_lo
      assign bch[j] = {1'b0, b[CH*j +: CH]};
    end else begin : g_hi
      assign bch[j] = (CH+1)'($signed(b[BW-1:CH*j]));
    end
  end

  // Row and total sums, modulo 2^PW (the exact product fits)
  always_comb begin
    p_next = '0;
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (PW'(pp[i][j]) <<< (CH * j));
      end
      p_next = p_next + (row[i] <<< (CH * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ach[i] * bch[j];
        end
        row[i] <= row_next[i];
      end
      p <= p_next;
    end
  end

endmodule

/* rtl/stc_div.sv */
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per stage, QB stages.
// The caller keeps num below den * 2^QB.
module stc_div #(
  parameter int NW = 171,
  parameter int DW = 139,
  parameter int QB = 36
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  localparam int RW = (NW > DW + QB) ? NW : DW + QB;

  logic [RW-1:0] rem [QB];
  logic [DW-1:0] dv  [QB];
  logic [QB-1:0] qt  [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [RW-1:0] rin;
    logic [RW-1:0] trial;
    logic [DW-1:0] din;
    logic [QB-1:0] qin;
    logic          ge;

    if (s == 0) begin : g_first
      assign rin = RW'(num);
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem[s-1];
      assign din = dv[s-1];
      assign qin = qt[s-1];
    end

    // Trial subtract of the divisor aligned to this quotient bit
    assign trial = RW'(din) << (QB - 1 - s);
    assign ge    = (rin >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? (rin - trial) : rin;
        dv[s]  <= din;
        qt[s]  <= {qin[QB-2:0], ge};
      end
    end
  end

  assign quo = qt[QB-1];

endmodule

/* rtl/sphere_triangle_contact_unit.sv */
`timescale 1ns / 1ps

// Sphere / triangle contact unit.
// Item channel: item_valid with item_stall; a transfer happens on a rising
// edge with item_valid high and item_stall low. Each item holds the sphere
// centre and three triangle vertices, signed Q16.16.
// Result channel: result_valid with result_stall, one result per item, in
// order: closest point on the triangle, hit (squared distance at most the
// radius squared) and degenerate (zero interior divisor, vertex a given).
// cfg_write_en writes the 31-bit radius; write it only while no item is in
// flight.
// One item may be transferred every cycle while item_stall is low; the
// 36-stage quotient pipe sets the depth.
// Synchronous reset empties the pipe and output stage and zeroes the radius.
// When the receiver stalls, the result holds and the pipe keeps moving into
// a one-entry skid; once that is full the whole pipe freezes and item_stall
// rises until the output drains.
module sphere_triangle_contact_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [30:0]        cfg_write_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic signed [31:0] tri_a_x,
  input  logic signed [31:0] tri_a_y,
  input  logic signed [31:0] tri_a_z,
  input  logic signed [31:0] tri_b_x,
  input  logic signed [31:0] tri_b_y,
  input  logic signed [31:0] tri_b_z,
  input  logic signed [31:0] tri_c_x,
  input  logic signed [31:0] tri_c_y,
  input  logic signed [31:0] tri_c_z,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               hit,
  output logic signed [31:0] contact_x,
  output logic signed [31:0] contact_y,
  output logic signed [31:0] contact_z,
  output logic               degenerate
);

  localparam int ML = stc_pkg::MUL_LAT;
  localparam int QB = stc_pkg::DIV_QBITS;
  localparam int PD = stc_pkg::PIPE_DEPTH;

  // Operand pairs for the weight products: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  localparam int M1A [6] = '{0, 2, 4, 0, 2, 4};
  localparam int M1B [6] = '{3, 1, 1, 5, 5, 3};

  logic [30:0]                 radius;
  logic [stc_pkg::RSQW-1:0]    rsq;
  logic                        en;
  logic [PD-1:0]               vld;
  logic                        push;

  stc_pkg::coord_t             pin [3];
  stc_pkg::coord_t             ain [3];
  stc_pkg::coord_t             bin [3];
  stc_pkg::coord_t             cin [3];

  stc_pkg::geo_t               s1_g;
  stc_pkg::diff_t              s1_ap [3];
  stc_pkg::diff_t              s1_bp [3];
  stc_pkg::diff_t              s1_cp [3];
  stc_pkg::geo_t               s2_g;
  stc_pkg::prod_t              pr [6][3];
  stc_pkg::vctx_t              s3;
  stc_pkg::vprod_t             m1p [6];
  stc_pkg::vctx_t              dl1 [ML];
  stc_pkg::vctx_t              s4;
  stc_pkg::vol_t               s4_va;
  stc_pkg::vol_t               s4_vb;
  stc_pkg::vol_t               s4_vc;

  stc_pkg::dot_t               ed [6];
  logic signed [stc_pkg::DOTW:0] d43;
  logic signed [stc_pkg::DOTW:0] d56;
  stc_pkg::coord_t             e_base [3];
  stc_pkg::vol_t               e_s1;
  stc_pkg::vol_t               e_s2;
  stc_pkg::diff_t              e_u1 [3];
  stc_pkg::diff_t              e_u2 [3];
  stc_pkg::den_t               e_den;
  logic                        e_deg;

  stc_pkg::ectx_t              s5;
  stc_pkg::vol_t               s5_s1;
  stc_pkg::vol_t               s5_s2;
  stc_pkg::diff_t              s5_u1 [3];
  stc_pkg::diff_t              s5_u2 [3];
  stc_pkg::nprod_t             m2p [6];
  stc_pkg::ectx_t              dl2 [ML];
  stc_pkg::ectx_t              s6;
  stc_pkg::num_t               s6_num [3];
  stc_pkg::qctx_t              s7;
  logic [stc_pkg::NUMW-1:0]    s7_nmag [3];
  logic [stc_pkg::DENW-1:0]    s7_dmag;
  logic [QB-1:0]               qmag [3];
  stc_pkg::qctx_t              dl3 [QB];
  stc_pkg::qctx_t              qc;
  stc_pkg::coord_t             s8_res [3];
  stc_pkg::coord_t             s8_p [3];
  logic                        s8_deg;
  stc_pkg::diff_t              s9_dk [3];
  stc_pkg::coord_t             s9_res [3];
  logic                        s9_deg;
  stc_pkg::prod_t              s10_sq [3];
  stc_pkg::coord_t             s10_res [3];
  logic                        s10_deg;

  logic [stc_pkg::DISTW-1:0]   sq_dist;
  logic                        phit;

  logic                        skid_v;
  logic                        skid_hit;
  logic                        skid_deg;
  stc_pkg::coord_t             skid_res [3];

  // Radius register and its square
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
    end else if (cfg_write_en) begin
      radius <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    rsq <= stc_pkg::RSQW'(radius) * stc_pkg::RSQW'(radius);
  end

  // Pipe moves unless the skid entry is occupied
  assign en         = !skid_v;
  assign item_stall = skid_v;
  assign push       = en && vld[PD-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PD-2:0], item_valid};
    end
  end

  assign pin = '{center_x, center_y, center_z};
  assign ain = '{tri_a_x, tri_a_y, tri_a_z};
  assign bin = '{tri_b_x, tri_b_y, tri_b_z};
  assign cin = '{tri_c_x, tri_c_y, tri_c_z};

  // Stage A: edge and centre differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_g.p[k]  <= pin[k];
        s1_g.a[k]  <= ain[k];
        s1_g.b[k]  <= bin[k];
        s1_g.c[k]  <= cin[k];
        s1_g.ab[k] <= stc_pkg::diff_t'(bin[k]) - stc_pkg::diff_t'(ain[k]);
        s1_g.ac[k] <= stc_pkg::diff_t'(cin[k]) - stc_pkg::diff_t'(ain[k]);
        s1_g.bc[k] <= stc_pkg::diff_t'(cin[k]) - stc_pkg::diff_t'(bin[k]);
        s1_ap[k]   <= stc_pkg::diff_t'(pin[k]) - stc_pkg::diff_t'(ain[k]);
        s1_bp[k]   <= stc_pkg::diff_t'(pin[k]) - stc_pkg::diff_t'(bin[k]);
        s1_cp[k]   <= stc_pkg::diff_t'(pin[k]) - stc_pkg::diff_t'(cin[k]);
      end
    end
  end

  // Stage B: products for the six dot products
  always_ff @(posedge clk) begin
    if (en) begin
      s2_g <= s1_g;
      for (int k = 0; k < 3; k++) begin
        pr[0][k] <= $signed(s1_g.ab[k]) * s1_ap[k];
        pr[1][k] <= $signed(s1_g.ac[k]) * s1_ap[k];
        pr[2][k] <= $signed(s1_g.ab[k]) * s1_bp[k];
        pr[3][k] <= $signed(s1_g.ac[k]) * s1_bp[k];
        pr[4][k] <= $signed(s1_g.ab[k]) * s1_cp[k];
        pr[5][k] <= $signed(s1_g.ac[k]) * s1_cp[k];
      end
    end
  end

  // Stage C: d1..d6
  always_ff @(posedge clk) begin
    if (en) begin
      s3.g <= s2_g;
      for (int j = 0; j < 6; j++) begin
        s3.d[j] <= stc_pkg::dot_t'(pr[j][0]) + stc_pkg::dot_t'(pr[j][1])
                 + stc_pkg::dot_t'(pr[j][2]);
      end
    end
  end

  // Weight products, context delayed alongside
  for (genvar j = 0; j < 6; j++) begin : g_m1
    stc_mul #(.AW(stc_pkg::DOTW), .BW(stc_pkg::DOTW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   ($signed(s3.d[M1A[j]])),
      .b   ($signed(s3.d[M1B[j]])),
      .p   (m1p[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl1[0] <= s3;
      for (int i = 1; i < ML; i++) begin
        dl1[i] <= dl1[i-1];
      end
    end
  end

  // Stage D: va, vb, vc
  always_ff @(posedge clk) begin
    if (en) begin
      s4    <= dl1[ML-1];
      s4_vc <= stc_pkg::vol_t'(m1p[0]) - stc_pkg::vol_t'(m1p[1]);
      s4_vb <= stc_pkg::vol_t'(m1p[2]) - stc_pkg::vol_t'(m1p[3]);
      s4_va <= stc_pkg::vol_t'(m1p[4]) - stc_pkg::vol_t'(m1p[5]);
    end
  end

  // Stage E: Voronoi region choice, in test order
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      ed[j] = $signed(s4.d[j]);
    end
    d43   = (stc_pkg::DOTW+1)'(ed[3]) - (stc_pkg::DOTW+1)'(ed[2]);
    d56   = (stc_pkg::DOTW+1)'(ed[4]) - (stc_pkg::DOTW+1)'(ed[5]);
    e_s1  = '0;
    e_s2  = '0;
    e_den = '0;
    e_deg = 1'b0;
    for (int k = 0; k < 3; k++) begin
      e_base[k] = $signed(s4.g.a[k]);
      e_u1[k]   = '0;
      e_u2[k]   = '0;
    end
    priority if (ed[0] <= 0 && ed[1] <= 0) begin
      // vertex a: defaults
    end else if (ed[2] >= 0 && d43 <= 0) begin
      for (int k = 0; k < 3; k++) e_base[k] = $signed(s4.g.b[k]);
    end else if (s4_vc <= 0 && ed[0] >= 0 && ed[2] <= 0) begin
      e_s1  = stc_pkg::vol_t'(ed[0]);
      e_den = stc_pkg::den_t'(ed[0]) - stc_pkg::den_t'(ed[2]);
      for (int k = 0; k < 3; k++) e_u1[k] = $signed(s4.g.ab[k]);
    end else if (ed[5] >= 0 && d56 <= 0) begin
      for (int k = 0; k < 3; k++) e_base[k] = $signed(s4.g.c[k]);
    end else if (s4_vb <= 0 && ed[1] >= 0 && ed[5] <= 0) begin
      e_s1  = stc_pkg::vol_t'(ed[1]);
      e_den = stc_pkg::den_t'(ed[1]) - stc_pkg::den_t'(ed[5]);
      for (int k = 0; k < 3; k++) e_u1[k] = $signed(s4.g.ac[k]);
    end else if (s4_va <= 0 && d43 >= 0 && d56 >= 0) begin
      e_s1  = stc_pkg::vol_t'(d43);
      e_den = stc_pkg::den_t'(d43) + stc_pkg::den_t'(d56);
      for (int k = 0; k < 3; k++) begin
        e_base[k] = $signed(s4.g.b[k]);
        e_u1[k]   = $signed(s4.g.bc[k]);
      end
    end else begin
      // interior: barycentric from a
      e_s1  = s4_vb;
      e_s2  = s4_vc;
      e_den = stc_pkg::den_t'(s4_va) + stc_pkg::den_t'(s4_vb)
            + stc_pkg::den_t'(s4_vc);
      e_deg = (e_den == '0);
      for (int k = 0; k < 3; k++) begin
        e_u1[k] = $signed(s4.g.ab[k]);
        e_u2[k] = $signed(s4.g.ac[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5.den <= e_den;
      s5.deg <= e_deg;
      s5_s1  <= e_s1;
      s5_s2  <= e_s2;
      for (int k = 0; k < 3; k++) begin
        s5.base[k] <= e_base[k];
        s5.p[k]    <= s4.g.p[k];
        s5_u1[k]   <= e_u1[k];
        s5_u2[k]   <= e_u2[k];
      end
    end
  end

  // Numerator products
  for (genvar k = 0; k < 3; k++) begin : g_m2
    stc_mul #(.AW(stc_pkg::VW), .BW(stc_pkg::DFW)) u_mul_a (
      .clk (clk),
      .en  (en),
      .a   (s5_s1),
      .b   (s5_u1[k]),
      .p   (m2p[k])
    );
    stc_mul #(.AW(stc_pkg::VW), .BW(stc_pkg::DFW)) u_mul_b (
      .clk (clk),
      .en  (en),
      .a   (s5_s2),
      .b   (s5_u2[k]),
      .p   (m2p[k+3])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl2[0] <= s5;
      for (int i = 1; i < ML; i++) begin
        dl2[i] <= dl2[i-1];
      end
    end
  end

  // Stage F: numerators
  always_ff @(posedge clk) begin
    if (en) begin
      s6 <= dl2[ML-1];
      for (int k = 0; k < 3; k++) begin
        s6_num[k] <= stc_pkg::num_t'(m2p[k]) + stc_pkg::num_t'(m2p[k+3]);
      end
    end
  end

  // Stage G: magnitudes and quotient signs
  always_ff @(posedge clk) begin
    if (en) begin
      s7.base  <= s6.base;
      s7.p     <= s6.p;
      s7.deg   <= s6.deg;
      s7.dzero <= (s6.den == '0);
      s7_dmag  <= $signed(s6.den) < 0 ? stc_pkg::DENW'(-$signed(s6.den))
                                      : stc_pkg::DENW'(s6.den);
      for (int k = 0; k < 3; k++) begin
        s7_nmag[k] <= s6_num[k] < 0 ? stc_pkg::NUMW'(-s6_num[k])
                                    : stc_pkg::NUMW'(s6_num[k]);
        s7.nneg[k] <= (s6_num[k] < 0) ^ ($signed(s6.den) < 0);
      end
    end
  end

  // Quotient pipes, one per axis
  for (genvar k = 0; k < 3; k++) begin : g_div
    stc_div #(.NW(stc_pkg::NUMW), .DW(stc_pkg::DENW), .QB(QB)) u_div (
      .clk (clk),
      .en  (en),
      .num (s7_nmag[k]),
      .den (s7_dmag),
      .quo (qmag[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl3[0] <= s7;
      for (int i = 1; i < QB; i++) begin
        dl3[i] <= dl3[i-1];
      end
    end
  end

  assign qc = dl3[QB-1];

  // Stage H: contact point, low 32 bits of base plus signed quotient, or base when the divisor is zero
  always_ff @(posedge clk) begin
    if (en) begin
      s8_deg <= qc.deg;
      for (int k = 0; k < 3; k++) begin
        s8_p[k] <= qc.p[k];
        if (qc.dzero) begin
          s8_res[k] <= qc.base[k];
        end else if (qc.nneg[k]) begin
          s8_res[k] <= qc.base[k] - qmag[k][stc_pkg::CW-1:0];
        end else begin
          s8_res[k] <= qc.base[k] + qmag[k][stc_pkg::CW-1:0];
        end
      end
    end
  end

  // Stage I: offset from the centre
  always_ff @(posedge clk) begin
    if (en) begin
      s9_deg <= s8_deg;
      for (int k = 0; k < 3; k++) begin
        s9_res[k] <= s8_res[k];
        s9_dk[k]  <= stc_pkg::diff_t'(s8_res[k]) - stc_pkg::diff_t'(s8_p[k]);
      end
    end
  end

  // Stage J: squares
  always_ff @(posedge clk) begin
    if (en) begin
      s10_deg <= s9_deg;
      for (int k = 0; k < 3; k++) begin
        s10_res[k] <= s9_res[k];
        s10_sq[k]  <= s9_dk[k] * s9_dk[k];
      end
    end
  end

  // Squared distance against radius squared
  assign sq_dist = stc_pkg::DISTW'(unsigned'(s10_sq[0]))
                 + stc_pkg::DISTW'(unsigned'(s10_sq[1]))
                 + stc_pkg::DISTW'(unsigned'(s10_sq[2]));
  assign phit = (sq_dist <= stc_pkg::DISTW'(rsq));

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_v       <= 1'b0;
    end else if (result_valid && result_stall) begin
      if (push) begin
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      result_valid <= 1'b1;
      skid_v       <= 1'b0;
    end else begin
      result_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && result_stall) begin
      if (push) begin
        skid_hit <= phit;
        skid_deg <= s10_deg;
        skid_res <= s10_res;
      end
    end else if (skid_v) begin
      hit        <= skid_hit;
      degenerate <= skid_deg;
      contact_x  <= skid_res[0];
      contact_y  <= skid_res[1];
      contact_z  <= skid_res[2];
    end else if (push) begin
      hit        <= phit;
      degenerate <= s10_deg;
      contact_x  <= s10_res[0];
      contact_y  <= s10_res[1];
      contact_z  <= s10_res[2];
    end
  end

endmodule

/* rtl/stc_checker.sv */
`timescale 1ns / 1ps

`include "sphere_triangle_contact_unit_macros.svh"

// Port-level checks on the contact unit's handshakes
module stc_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic               hit,
  input logic signed [31:0] contact_x
);

  // Reset empties the output stage
  `STC_ASSERT_RST(a_reset_empty, !result_valid)

  // Input is held back only while a result is waiting
  `STC_ASSERT_IMP(a_stall_has_result, item_stall, result_valid)

  // Input stall only starts after the receiver stalled a result
  `STC_ASSERT_IMP(a_stall_cause, $rose(item_stall), $past(result_valid && result_stall))

  // A stalled result stays put
  `STC_ASSERT_NXT(a_result_hold, result_valid && result_stall,
                  result_valid && $stable(contact_x) && $stable(hit))

endmodule

bind sphere_triangle_contact_unit stc_checker u_stc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .hit          (hit),
  .contact_x    (contact_x)
);

/* tb/sphere_triangle_contact_unit_tb.sv */
`timescale 1ns / 1ps

module sphere_triangle_contact_unit_tb;

  typedef logic signed [255:0] wide_t;

  // one triangle test: centre, then vertices a, b, c (x, y, z each)
  typedef struct {
    stc_pkg::coord_t v[12];
  } tri_test_t;

  typedef struct {
    logic            hit;
    stc_pkg::coord_t pt[3];
    logic            deg;
  } contact_t;

  localparam stc_pkg::coord_t ONE  = 32'sh0001_0000;
  localparam stc_pkg::coord_t CMAX = 32'sh7FFF_FFFF;
  localparam stc_pkg::coord_t CMIN = -32'sh7FFF_FFFF - 1;
  localparam int LATENCY  = 52;

  logic clk, rst;
  logic cfg_write_en;
  logic [30:0] cfg_write_data;
  logic item_valid, item_stall;
  stc_pkg::coord_t center_x, center_y, center_z;
  stc_pkg::coord_t tri_a_x, tri_a_y, tri_a_z;
  stc_pkg::coord_t tri_b_x, tri_b_y, tri_b_z;
  stc_pkg::coord_t tri_c_x, tri_c_y, tri_c_z;
  logic result_valid, result_stall;
  logic hit, degenerate;
  stc_pkg::coord_t contact_x, contact_y, contact_z;

  sphere_triangle_contact_unit uut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .tri_a_x(tri_a_x), .tri_a_y(tri_a_y), .tri_a_z(tri_a_z),
    .tri_b_x(tri_b_x), .tri_b_y(tri_b_y), .tri_b_z(tri_b_z),
    .tri_c_x(tri_c_x), .tri_c_y(tri_c_y), .tri_c_z(tri_c_z),
    .result_valid(result_valid), .result_stall(result_stall),
    .hit(hit), .contact_x(contact_x), .contact_y(contact_y),
    .contact_z(contact_z), .degenerate(degenerate)
  );

  contact_t    contact_q[$];
  logic [30:0] radius;
  int          errors;
  int          n_sent, n_checked, n_hits, n_deg;
  bit          idle_en;
  bit          long_hold;
  bit          took;
  int          stall_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout at %0t", $time);
    $display("DONE: errors detected");
    $finish;
  end

  // edge point or interior point; base when divisor is zero
  function automatic stc_pkg::coord_t place_coord(wide_t base, wide_t num, wide_t den);
    wide_t v;
    v = base;
    if (den != 0) v = base + num / den;
    return v[31:0];
  endfunction

  // closest point on the triangle, Voronoi regions in fixed order
  function automatic contact_t closest_contact(tri_test_t t, logic [30:0] rad);
    wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, den, sq_dist, dk, r2, rw;
    contact_t r;
    for (int k = 0; k < 3; k++) begin
      p[k] = t.v[k]; a[k] = t.v[3+k]; b[k] = t.v[6+k]; c[k] = t.v[9+k];
      ab[k] = b[k] - a[k]; ac[k] = c[k] - a[k]; bc[k] = c[k] - b[k];
      ap[k] = p[k] - a[k]; bp[k] = p[k] - b[k]; cp[k] = p[k] - c[k];
    end
    d1 = 0; d2 = 0; d3 = 0; d4 = 0; d5 = 0; d6 = 0;
    for (int k = 0; k < 3; k++) begin
      d1 += ab[k] * ap[k]; d2 += ac[k] * ap[k];
      d3 += ab[k] * bp[k]; d4 += ac[k] * bp[k];
      d5 += ab[k] * cp[k]; d6 += ac[k] * cp[k];
    end
    vc = d1 * d4 - d3 * d2;
    vb = d5 * d2 - d1 * d6;
    va = d3 * d6 - d5 * d4;
    r.deg = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (d1 <= 0 && d2 <= 0)
        r.pt[k] = a[k][31:0];
      else if (d3 >= 0 && d4 - d3 <= 0)
        r.pt[k] = b[k][31:0];
      else if (vc <= 0 && d1 >= 0 && d3 <= 0)
        r.pt[k] = place_coord(a[k], d1 * ab[k], d1 - d3);
      else if (d6 >= 0 && d5 - d6 <= 0)
        r.pt[k] = c[k][31:0];
      else if (vb <= 0 && d2 >= 0 && d6 <= 0)
        r.pt[k] = place_coord(a[k], d2 * ac[k], d2 - d6);
      else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0)
        r.pt[k] = place_coord(b[k], (d4 - d3) * bc[k], (d4 - d3) + (d5 - d6));
      else begin
        den = va + vb + vc;
        r.deg = (den == 0);
        r.pt[k] = place_coord(a[k], vb * ab[k] + vc * ac[k], den);
      end
    end
    sq_dist = 0;
    for (int k = 0; k < 3; k++) begin
      dk = r.pt[k];
      dk = dk - p[k];
      sq_dist += dk * dk;
    end
    rw = rad;
    r2 = rw * rw;
    r.hit = (sq_dist <= r2);
    return r;
  endfunction

  // result side: stall pattern
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_cnt = 0;
    end else if (long_hold) begin
      result_stall <= 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      result_stall <= 1'b1;
    end else begin
      if (took && idle_en && $urandom_range(0, 1)) stall_cnt = $urandom_range(0, 13);
      result_stall <= (stall_cnt > 0);
    end
  end

  // result side: sample midway through the cycle, transfer at next edge
  always @(negedge clk) begin
    contact_t e;
    took = !rst && result_valid && !result_stall;
    if (took) begin
      if (contact_q.size() == 0) begin
        $display("%0t: result with none expected: hit %b pt %h %h %h deg %b", $time,
                 hit, contact_x, contact_y, contact_z, degenerate);
        errors++;
      end else begin
        e = contact_q.pop_front();
        n_checked++;
        if (e.hit) n_hits++;
        if (e.deg) n_deg++;
        if (hit !== e.hit) begin
          $display("%0t: hit exp %b got %b", $time, e.hit, hit); errors++;
        end
        if (contact_x !== e.pt[0]) begin
          $display("%0t: contact_x exp %h got %h", $time, e.pt[0], contact_x); errors++;
        end
        if (contact_y !== e.pt[1]) begin
          $display("%0t: contact_y exp %h got %h", $time, e.pt[1], contact_y); errors++;
        end
        if (contact_z !== e.pt[2]) begin
          $display("%0t: contact_z exp %h got %h", $time, e.pt[2], contact_z); errors++;
        end
        if (degenerate !== e.deg) begin
          $display("%0t: degenerate exp %b got %b", $time, e.deg, degenerate); errors++;
        end
      end
    end
  end

  // one item transfer; valid stays high when the next item follows at once
  task automatic send_test(tri_test_t t);
    int gap;
    bit done;
    gap = idle_en && $urandom_range(0, 1) ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    {center_x, center_y, center_z} <= {t.v[0], t.v[1], t.v[2]};
    {tri_a_x, tri_a_y, tri_a_z} <= {t.v[3], t.v[4], t.v[5]};
    {tri_b_x, tri_b_y, tri_b_z} <= {t.v[6], t.v[7], t.v[8]};
    {tri_c_x, tri_c_y, tri_c_z} <= {t.v[9], t.v[10], t.v[11]};
    do begin
      @(negedge clk);
      done = !item_stall;
      @(posedge clk);
    end while (!done);
    contact_q.push_back(closest_contact(t, radius));
    n_sent++;
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_radius(logic [30:0] r);
    drain_results();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= r;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    radius = r;
  endtask

  function automatic tri_test_t make_test(stc_pkg::coord_t p[3], stc_pkg::coord_t a[3],
                                         stc_pkg::coord_t b[3], stc_pkg::coord_t c[3]);
    tri_test_t t;
    for (int k = 0; k < 3; k++) begin
      t.v[k] = p[k]; t.v[3+k] = a[k]; t.v[6+k] = b[k]; t.v[9+k] = c[k];
    end
    return t;
  endfunction

  // random test: raw, local mesh patch, collinear or coincident vertices
  function automatic tri_test_t random_test();
    tri_test_t t;
    stc_pkg::coord_t org[3];
    int kind, span;
    kind = $urandom_range(0, 9);
    span = $urandom_range(4, 20);
    for (int k = 0; k < 3; k++) org[k] = $urandom;
    for (int i = 0; i < 12; i++)
      t.v[i] = org[i % 3]
             + stc_pkg::coord_t'($signed($urandom_range(0, 2 ** span)) - 2 ** (span - 1));
    if (kind < 2) begin
      for (int i = 0; i < 12; i++) t.v[i] = $urandom;
    end else if (kind == 2) begin
      // c on the line through a and b
      for (int k = 0; k < 3; k++)
        t.v[9+k] = t.v[3+k] + (t.v[6+k] - t.v[3+k]) * $signed($urandom_range(0, 4) - 2);
    end else if (kind == 3) begin
      case ($urandom_range(0, 2))
        0: for (int k = 0; k < 3; k++) t.v[6+k] = t.v[3+k];
        1: for (int k = 0; k < 3; k++) t.v[9+k] = t.v[3+k];
        default: for (int k = 0; k < 3; k++) t.v[9+k] = t.v[6+k];
      endcase
    end
    return t;
  endfunction

  // regions of a unit right triangle, extremes, degenerate shapes
  task automatic test_directed();
    stc_pkg::coord_t a[3], b[3], c[3], p[3];
    a = '{0, 0, 0}; b = '{ONE, 0, 0}; c = '{0, ONE, 0};
    p = '{-ONE, -ONE, 0};              send_test(make_test(p, a, b, c));
    p = '{2 * ONE, -ONE, ONE};         send_test(make_test(p, a, b, c));
    p = '{ONE / 3, -ONE, -ONE};        send_test(make_test(p, a, b, c));
    p = '{-ONE, 2 * ONE, 0};           send_test(make_test(p, a, b, c));
    p = '{-ONE, ONE / 3, ONE};         send_test(make_test(p, a, b, c));
    p = '{ONE, ONE, 0};                send_test(make_test(p, a, b, c));
    p = '{ONE / 4, ONE / 3, ONE};      send_test(make_test(p, a, b, c));
    p = '{ONE / 7, ONE / 5, -7};       send_test(make_test(p, a, b, c));
    // all points the same
    p = '{0, 0, 0};                    send_test(make_test(p, p, p, p));
    // collinear triangle, centre off the line
    c = '{ONE / 2, 0, 0}; b = '{ONE, 0, 0};
    p = '{ONE / 2, ONE, 0};            send_test(make_test(p, a, b, c));
    p = '{ONE / 3, -ONE, ONE};         send_test(make_test(p, a, c, b));
    // coincident vertices: b on a, then c on b
    b = a; c = '{0, ONE, 0};
    p = '{ONE, ONE / 2, 0};            send_test(make_test(p, a, b, c));
    b = '{ONE, 0, 0}; c = b;
    p = '{ONE / 2, ONE, 0};            send_test(make_test(p, a, b, c));
    // extremes of the coordinate range
    a = '{CMIN, CMIN, CMIN}; b = '{CMAX, CMIN, CMAX}; c = '{CMIN, CMAX, CMAX};
    p = '{CMAX, CMAX, CMIN};           send_test(make_test(p, a, b, c));
    p = '{CMIN, CMIN, CMIN};           send_test(make_test(p, a, b, c));
    p = '{0, 0, 0};                    send_test(make_test(p, a, b, c));
    a = '{CMAX, CMAX, CMAX}; b = '{CMIN, CMIN, CMIN}; c = '{CMAX, CMIN, 0};
    p = '{CMIN, CMAX, -1};             send_test(make_test(p, a, b, c));
    p = '{CMAX, CMIN, CMAX};           send_test(make_test(p, c, a, b));
  endtask

  task automatic test_random(int n);
    repeat (n) send_test(random_test());
  endtask

  // receiver holds off long while items keep coming, then pause to drain
  task automatic test_backpressure();
    bit save;
    save = idle_en;
    idle_en = 0;
    fork
      begin
        @(negedge clk) long_hold = 1;
        repeat (150) @(negedge clk);
        long_hold = 0;
      end
      test_random(120);
    join
    idle_en = save;
    drain_results();
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    item_valid     <= 1'b0;
    {center_x, center_y, center_z} <= '0;
    {tri_a_x, tri_a_y, tri_a_z}    <= '0;
    {tri_b_x, tri_b_y, tri_b_z}    <= '0;
    {tri_c_x, tri_c_y, tri_c_z}    <= '0;
    radius = '0; errors = 0; idle_en = 1; long_hold = 0; took = 0;
    n_sent = 0; n_checked = 0; n_hits = 0; n_deg = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    write_radius(31'h7FFF_FFFF);
    test_directed();
    write_radius(31'(ONE));
    test_directed();
    write_radius(31'h0004_0000);
    test_random(150);
    test_backpressure();
    write_radius(31'($urandom_range(0, 32'h0008_0000)));
    idle_en = 0;
    test_random(100);
    idle_en = 1;
    write_radius('0);
    test_random(100);
    write_radius(31'h0000_8000 | 31'($urandom_range(0, 32'h0010_0000)));
    test_random(200);
    write_radius(31'h7FFF_FFFF);
    test_random(30);
    drain_results();

    $display("sent %0d triangle tests over a range of radius settings, checked %0d results",
             n_sent, n_checked);
    $display("with %0d hits and %0d degenerate interiors", n_hits, n_deg);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
